>>> hdl/moacc_pkg.sv
// Shared constants for the multichannel oversampling accumulator.
package moacc_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int FACTOR_W     = 13;
    localparam int VALUE_W      = 12;
    localparam int MV_W         = 15;
    localparam int CHAN_W       = 3;
    localparam int COUNT_W      = 32;
    localparam int LSB_DROP     = 2;
    localparam int FACTOR_SHIFT = 10;
    localparam int PROD_W       = VALUE_W + FACTOR_W;

    localparam logic [VALUE_W-1:0]  VALUE_MAX       = 12'd4095;
    localparam logic [FACTOR_W-1:0] MV_FACTOR_RESET = 13'd743;

    localparam int NUM_CH_DEF  = 8;
    localparam int PASSES_DEF  = 16;
    localparam int QUEUE_DEPTH = 4;

endpackage

>>> hdl/moacc_front.sv
// Front end: takes samples, tracks the mux pointer and pass count, and queues commands.
module moacc_front import moacc_pkg::*;
#(
    parameter int NUM_CH = NUM_CH_DEF,
    parameter int PASSES = PASSES_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [SAMPLE_W-1:0]                     raw_sample,
    input  logic                                    q_full,
    output logic                                    q_push,
    output logic [SAMPLE_W+$clog2(NUM_CH):0]        q_data
);

    localparam int CH_W   = $clog2(NUM_CH);
    localparam int PASS_W = $clog2(PASSES);

    localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(NUM_CH - 1);
    localparam logic [CH_W-1:0]   PTR_RESET = CH_W'(1 % NUM_CH);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(PASSES - 1);

    logic [CH_W-1:0]   ptr_reg;
    logic [CH_W-1:0]   ptr_next;
    logic [PASS_W-1:0] pass_reg;
    logic [PASS_W-1:0] pass_next;
    logic [CH_W-1:0]   target;
    logic              wrap;
    logic              emit;
    logic              accept;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign q_push   = accept;

    assign wrap   = (ptr_reg == '0);
    assign target = wrap ? LAST_CH : ptr_reg - CH_W'(1);
    assign emit   = wrap && (pass_reg == LAST_PASS);
    assign q_data = {emit, target, raw_sample};

    always_comb
    begin
        ptr_next  = ptr_reg;
        pass_next = pass_reg;
        if (accept)
        begin
            ptr_next = (ptr_reg == LAST_CH) ? '0 : ptr_reg + CH_W'(1);
            if (wrap)
            begin
                pass_next = emit ? '0 : pass_reg + PASS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= PTR_RESET;
            pass_reg <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            pass_reg <= pass_next;
        end
    end

endmodule

>>> hdl/moacc_queue.sv
// Small command queue between the front end and the accumulator back end.
module moacc_queue import moacc_pkg::*;
#(
    parameter int DATA_W = 14,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

>>> hdl/moacc_back.sv
// Back end: per-channel accumulators, set counter and the result burst sequencer.
module moacc_back import moacc_pkg::*;
#(
    parameter int NUM_CH = NUM_CH_DEF,
    parameter int PASSES = PASSES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  logic [SAMPLE_W+$clog2(NUM_CH):0]    q_data,
    output logic                                q_pop,
    input  logic [FACTOR_W-1:0]                 mv_factor,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [CHAN_W-1:0]                   channel,
    output logic [VALUE_W-1:0]                  value,
    output logic [MV_W-1:0]                     millivolts,
    output logic [COUNT_W-1:0]                  set_count,
    output logic                                last
);

    localparam int CH_W  = $clog2(NUM_CH);
    localparam int ACC_W = SAMPLE_W + $clog2(PASSES);
    localparam int SH_W  = ACC_W - LSB_DROP;
    localparam int EXT_W = (SH_W > VALUE_W) ? SH_W : VALUE_W;
    localparam int CHX_W = (CH_W > CHAN_W) ? CH_W : CHAN_W;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_MUL  = 4'b0100,
        S_SEND = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [ACC_W-1:0]   acc_reg [NUM_CH];
    logic [CH_W-1:0]    idx_reg;
    logic [COUNT_W-1:0] sets_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [MV_W-1:0]    mv_reg;
    logic               out_valid_reg;
    logic [CHAN_W-1:0]  channel_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [MV_W-1:0]    mv_out_reg;
    logic [COUNT_W-1:0] set_count_reg;
    logic               last_reg;

    logic               cmd_emit;
    logic [CH_W-1:0]    cmd_ch;
    logic [SAMPLE_W-1:0] cmd_sample;
    logic [CH_W-1:0]    addr;
    logic [ACC_W-1:0]   acc_rd;
    logic [ACC_W-1:0]   acc_sum;
    logic [SH_W-1:0]    shifted;
    logic [EXT_W-1:0]   shifted_ext;
    logic [VALUE_W-1:0] val_sat;
    logic [PROD_W-1:0]  product;
    logic [CHX_W-1:0]   idx_ext;
    logic               slot_free;
    logic               send;

    assign {cmd_emit, cmd_ch, cmd_sample} = q_data;

    assign q_pop   = (state_reg == S_IDLE) && !q_empty;
    assign addr    = (state_reg == S_IDLE) ? cmd_ch : idx_reg;
    assign acc_rd  = acc_reg[addr];
    assign acc_sum = acc_rd + ACC_W'(cmd_sample);

    assign shifted     = acc_rd[ACC_W-1:LSB_DROP];
    assign shifted_ext = EXT_W'(shifted);
    assign val_sat     = (shifted_ext > EXT_W'(VALUE_MAX)) ? VALUE_MAX
                                                          : shifted_ext[VALUE_W-1:0];

    assign product = PROD_W'(val_reg) * PROD_W'(mv_factor);
    assign idx_ext = CHX_W'(idx_reg);

    assign slot_free = !out_valid_reg || !out_stall;
    assign send      = (state_reg == S_SEND) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop && cmd_emit)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (slot_free)
                begin
                    state_next = (idx_reg == LAST_CH) ? S_IDLE : S_LOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            sets_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                acc_reg[cmd_ch] <= acc_sum;
                if (cmd_emit)
                begin
                    sets_reg <= sets_reg + COUNT_W'(1);
                    idx_reg  <= '0;
                end
            end
            if (state_reg == S_LOAD)
            begin
                acc_reg[idx_reg] <= '0;
            end
            if (send)
            begin
                out_valid_reg <= 1'b1;
                if (idx_reg != LAST_CH)
                begin
                    idx_reg <= idx_reg + CH_W'(1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            val_reg <= val_sat;
        end
        if (state_reg == S_MUL)
        begin
            mv_reg <= product[FACTOR_SHIFT +: MV_W];
        end
        if (send)
        begin
            channel_reg   <= idx_ext[CHAN_W-1:0];
            value_reg     <= val_reg;
            mv_out_reg    <= mv_reg;
            set_count_reg <= sets_reg;
            last_reg      <= (idx_reg == LAST_CH);
        end
    end

    assign out_valid  = out_valid_reg;
    assign channel    = channel_reg;
    assign value      = value_reg;
    assign millivolts = mv_out_reg;
    assign set_count  = set_count_reg;
    assign last       = last_reg;

endmodule

>>> hdl/multichannel_oversampling_accumulator_top.sv
// Top level of the multichannel oversampling accumulator.
// The block takes one converter sample per cycle while its four-entry command queue has
// room. Outside a result burst the accumulator stage applies one queued sample per cycle to
// the channel before the mux pointer. The sample that closes the last pass of a set starts
// a result burst, taking each channel through accumulator read, scaling multiply and output
// register and held while the output stalls; samples keep entering the queue meanwhile and
// stall only once it fills. The accumulators are cleared directly by reset, with no
// clearing pass. The mv_factor register may be written at any time the block is idle.
module multichannel_oversampling_accumulator_top import moacc_pkg::*;
#(
    parameter int NUM_CH = NUM_CH_DEF,
    parameter int PASSES = PASSES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] raw_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CHAN_W-1:0]   channel,
    output logic [VALUE_W-1:0]  value,
    output logic [MV_W-1:0]     millivolts,
    output logic [COUNT_W-1:0]  set_count,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [FACTOR_W-1:0] cfg_data
);

    localparam int ENTRY_W = 1 + $clog2(NUM_CH) + SAMPLE_W;

    logic [FACTOR_W-1:0] mv_factor_reg;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [ENTRY_W-1:0]  q_wr_data;
    logic [ENTRY_W-1:0]  q_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_factor_reg <= MV_FACTOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mv_factor_reg <= cfg_data;
        end
    end

    moacc_front #(
        .NUM_CH (NUM_CH),
        .PASSES (PASSES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    moacc_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    moacc_back #(
        .NUM_CH (NUM_CH),
        .PASSES (PASSES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .mv_factor  (mv_factor_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .channel    (channel),
        .value      (value),
        .millivolts (millivolts),
        .set_count  (set_count),
        .last       (last)
    );

endmodule
